FILE: design/mlsfm_pkg.sv
package mlsfm_pkg;

   localparam int LANES           = 4;
   localparam int DIRECT_PORTS    = 4;
   localparam int NEIGHBOUR_PORTS = 2;
   localparam int FIFO_DEPTH      = 64;
   localparam int STUB_WIDTH      = 32;
   localparam int STAMP_WIDTH     = 32;

   localparam int DATA_BITS   = (STUB_WIDTH > STAMP_WIDTH) ? STUB_WIDTH : STAMP_WIDTH;
   localparam int WORD_WIDTH  = DATA_BITS + 1;
   localparam int PTR_WIDTH   = $clog2(FIFO_DEPTH);
   localparam int COUNT_WIDTH = $clog2(FIFO_DEPTH + 1);

   // one pop step, one step per push slot, one result step
   localparam int SLOTS      = DIRECT_PORTS + NEIGHBOUR_PORTS + 1;
   localparam int STEP_WIDTH = $clog2(SLOTS + 2);

   typedef logic [WORD_WIDTH-1:0]  word_type;
   typedef logic [PTR_WIDTH-1:0]   ptr_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [STEP_WIDTH-1:0]  step_type;

   localparam step_type STEP_POP  = '0;
   localparam step_type STEP_LAST = STEP_WIDTH'(SLOTS + 1);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } ctl_state_type;

   typedef struct packed {
      logic     run;
      step_type step;
      logic     push_valid;
      logic     push_stamp;
      word_type push_word;
   } lane_ctl_type;

   typedef struct packed {
      logic popped;
      logic dropped;
   } lane_stat_type;

   function automatic ptr_type ptr_next(ptr_type p);
      return (p == PTR_WIDTH'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

endpackage

FILE: design/mlsfm_ram.sv
module mlsfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         storage_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= storage_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/mlsfm_lane.sv
module mlsfm_lane (
   input  logic                     clock,
   input  logic                     reset,
   input  mlsfm_pkg::lane_ctl_type  ctl,
   input  logic                     write_en,
   input  logic                     read_en,
   output mlsfm_pkg::lane_stat_type stat,
   output mlsfm_pkg::word_type      word
);

   mlsfm_pkg::ptr_type   head_ff, head_in;
   mlsfm_pkg::ptr_type   tail_ff, tail_in;
   mlsfm_pkg::count_type count_ff, count_in;
   logic                 popped_ff, popped_in;
   logic                 dropped_ff, dropped_in;
   logic                 rd_en;
   logic                 wr_en;
   logic                 do_push;
   mlsfm_pkg::word_type  rd_data;

   mlsfm_ram #(
      .WIDTH (mlsfm_pkg::WORD_WIDTH),
      .DEPTH (mlsfm_pkg::FIFO_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (ctl.push_word),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      popped_in  = popped_ff;
      dropped_in = dropped_ff;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      do_push    = 1'b0;
      if (ctl.run) begin
         if (ctl.step == mlsfm_pkg::STEP_POP) begin
            // pop sees the fill level from before this request's pushes
            dropped_in = 1'b0;
            popped_in  = read_en && (count_ff != '0);
            rd_en      = popped_in;
            if (popped_in) begin
               head_in  = mlsfm_pkg::ptr_next(head_ff);
               count_in = count_ff - 1'b1;
            end
         end else if (ctl.step != mlsfm_pkg::STEP_LAST) begin
            // stamp only goes in when the fifo holds something
            do_push = write_en && ctl.push_valid && (!ctl.push_stamp || (count_ff != '0));
            if (do_push) begin
               if (count_ff == mlsfm_pkg::COUNT_WIDTH'(mlsfm_pkg::FIFO_DEPTH)) begin
                  dropped_in = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  tail_in  = mlsfm_pkg::ptr_next(tail_ff);
                  count_in = count_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         popped_ff  <= 1'b0;
         dropped_ff <= 1'b0;
      end else begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         popped_ff  <= popped_in;
         dropped_ff <= dropped_in;
      end
   end

   assign stat.popped  = popped_ff;
   assign stat.dropped = dropped_ff;
   assign word         = popped_ff ? rd_data : '0;

endmodule

FILE: design/multi_lane_stub_fifo_manager_unit.sv
// a request runs through the pop read, one step per push slot and the result load;
// req_stall holds off the next request until the result load, as the per-lane fifo
// ram write port takes one entry a cycle over all push slots
// a finished result waits in the output register while the next request is taken
// reset (synchronous, active high) empties all lane fifos; stored data is not cleared
module multi_lane_stub_fifo_manager_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [mlsfm_pkg::LANES-1:0]           req_write_lanes,
   input  logic [mlsfm_pkg::LANES-1:0]           req_read_lanes,
   input  logic [mlsfm_pkg::STAMP_WIDTH-1:0]     req_stamp_value,
   input  logic [mlsfm_pkg::DIRECT_PORTS-1:0]    req_stub_valid,
   input  logic [mlsfm_pkg::STUB_WIDTH-1:0]      req_stub_a,
   input  logic [mlsfm_pkg::STUB_WIDTH-1:0]      req_stub_b,
   input  logic [mlsfm_pkg::STUB_WIDTH-1:0]      req_stub_c,
   input  logic [mlsfm_pkg::STUB_WIDTH-1:0]      req_stub_d,
   input  logic [mlsfm_pkg::NEIGHBOUR_PORTS-1:0] req_neighbour_valid,
   input  logic [mlsfm_pkg::STUB_WIDTH-1:0]      req_neighbour_a,
   input  logic [mlsfm_pkg::STUB_WIDTH-1:0]      req_neighbour_b,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [mlsfm_pkg::LANES-1:0]           rsp_out_valid,
   output mlsfm_pkg::word_type                   rsp_lane_word_a,
   output mlsfm_pkg::word_type                   rsp_lane_word_b,
   output mlsfm_pkg::word_type                   rsp_lane_word_c,
   output mlsfm_pkg::word_type                   rsp_lane_word_d,
   output logic [mlsfm_pkg::LANES-1:0]           rsp_overflow_lanes
);

   mlsfm_pkg::ctl_state_type state_ff, state_in;
   mlsfm_pkg::step_type      step_ff, step_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     req_accept;
   logic                     finish;

   logic [mlsfm_pkg::LANES-1:0]           write_lanes_ff;
   logic [mlsfm_pkg::LANES-1:0]           read_lanes_ff;
   logic [mlsfm_pkg::STAMP_WIDTH-1:0]     stamp_ff;
   logic [mlsfm_pkg::DIRECT_PORTS-1:0]    stub_valid_ff;
   logic [mlsfm_pkg::NEIGHBOUR_PORTS-1:0] nb_valid_ff;
   logic [mlsfm_pkg::STUB_WIDTH-1:0]      stub_in [mlsfm_pkg::DIRECT_PORTS];
   logic [mlsfm_pkg::STUB_WIDTH-1:0]      stub_ff [mlsfm_pkg::DIRECT_PORTS];
   logic [mlsfm_pkg::STUB_WIDTH-1:0]      nb_in [mlsfm_pkg::NEIGHBOUR_PORTS];
   logic [mlsfm_pkg::STUB_WIDTH-1:0]      nb_ff [mlsfm_pkg::NEIGHBOUR_PORTS];

   mlsfm_pkg::lane_ctl_type  lane_ctl;
   mlsfm_pkg::lane_stat_type lane_stat [mlsfm_pkg::LANES];
   mlsfm_pkg::word_type      lane_word [mlsfm_pkg::LANES];

   logic [mlsfm_pkg::LANES-1:0] out_valid_ff;
   logic [mlsfm_pkg::LANES-1:0] overflow_ff;
   mlsfm_pkg::word_type         word_ff [mlsfm_pkg::LANES];

   assign stub_in[0] = req_stub_a;
   assign stub_in[1] = req_stub_b;
   assign stub_in[2] = req_stub_c;
   assign stub_in[3] = req_stub_d;
   assign nb_in[0]   = req_neighbour_a;
   assign nb_in[1]   = req_neighbour_b;

   assign req_stall  = (state_ff != mlsfm_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      finish       = 1'b0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         mlsfm_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = mlsfm_pkg::ST_RUN;
               step_in  = mlsfm_pkg::STEP_POP;
            end
         end
         mlsfm_pkg::ST_RUN: begin
            if (step_ff != mlsfm_pkg::STEP_LAST) begin
               step_in = step_ff + 1'b1;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               finish       = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = mlsfm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mlsfm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlsfm_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         write_lanes_ff <= req_write_lanes;
         read_lanes_ff  <= req_read_lanes;
         stamp_ff       <= req_stamp_value;
         stub_valid_ff  <= req_stub_valid;
         nb_valid_ff    <= req_neighbour_valid;
         stub_ff        <= stub_in;
         nb_ff          <= nb_in;
      end
   end

   // slot selection shared by all lanes: direct stubs, neighbour stubs, then stamp
   always_comb begin
      lane_ctl.run        = (state_ff == mlsfm_pkg::ST_RUN);
      lane_ctl.step       = step_ff;
      lane_ctl.push_valid = 1'b0;
      lane_ctl.push_stamp = 1'b0;
      lane_ctl.push_word  = '0;
      for (int p = 0; p < mlsfm_pkg::DIRECT_PORTS; p++) begin
         if (step_ff == mlsfm_pkg::STEP_WIDTH'(p + 1)) begin
            lane_ctl.push_valid = stub_valid_ff[p];
            lane_ctl.push_word  = mlsfm_pkg::WORD_WIDTH'(stub_ff[p]);
         end
      end
      for (int p = 0; p < mlsfm_pkg::NEIGHBOUR_PORTS; p++) begin
         if (step_ff == mlsfm_pkg::STEP_WIDTH'(mlsfm_pkg::DIRECT_PORTS + p + 1)) begin
            lane_ctl.push_valid = nb_valid_ff[p];
            lane_ctl.push_word  = mlsfm_pkg::WORD_WIDTH'(nb_ff[p]);
         end
      end
      if (step_ff == mlsfm_pkg::STEP_WIDTH'(mlsfm_pkg::SLOTS)) begin
         lane_ctl.push_valid = 1'b1;
         lane_ctl.push_stamp = 1'b1;
         lane_ctl.push_word  = {1'b1, mlsfm_pkg::DATA_BITS'(stamp_ff)};
      end
   end

   for (genvar g = 0; g < mlsfm_pkg::LANES; g++) begin : g_lane
      mlsfm_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (lane_ctl),
         .write_en (write_lanes_ff[g]),
         .read_en  (read_lanes_ff[g]),
         .stat     (lane_stat[g]),
         .word     (lane_word[g])
      );
   end

   // merge lane results into the output register
   always_ff @(posedge clock) begin
      if (finish) begin
         for (int l = 0; l < mlsfm_pkg::LANES; l++) begin
            out_valid_ff[l] <= lane_stat[l].popped;
            overflow_ff[l]  <= lane_stat[l].dropped;
            word_ff[l]      <= lane_word[l];
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_valid      = out_valid_ff;
   assign rsp_overflow_lanes = overflow_ff;
   assign rsp_lane_word_a    = word_ff[0];
   assign rsp_lane_word_b    = word_ff[1];
   assign rsp_lane_word_c    = word_ff[2];
   assign rsp_lane_word_d    = word_ff[3];

endmodule

FILE: bench/multi_lane_stub_fifo_manager_unit_test.sv
module multi_lane_stub_fifo_manager_unit_test;

   localparam int LANES           = mlsfm_pkg::LANES;
   localparam int DIRECT_PORTS    = mlsfm_pkg::DIRECT_PORTS;
   localparam int NEIGHBOUR_PORTS = mlsfm_pkg::NEIGHBOUR_PORTS;
   localparam int FIFO_DEPTH      = mlsfm_pkg::FIFO_DEPTH;
   localparam int STUB_WIDTH      = mlsfm_pkg::STUB_WIDTH;
   localparam int STAMP_WIDTH     = mlsfm_pkg::STAMP_WIDTH;
   localparam int DATA_BITS       = mlsfm_pkg::DATA_BITS;

   typedef mlsfm_pkg::word_type word_type;

   localparam int PORT_SLOTS     = DIRECT_PORTS + NEIGHBOUR_PORTS;
   localparam int RANDOM_ITEMS   = 1400;
   localparam int CALM_ITEMS     = 150;
   localparam int SETTLE_CYCLES  = 40;
   localparam int PRINT_LIMIT    = 200;
   localparam word_type STAMP_TAG = word_type'(1) << DATA_BITS;

   typedef logic [0:PORT_SLOTS-1][STUB_WIDTH-1:0] port_data_type;

   typedef struct packed {
      logic [LANES-1:0]                             write_lanes;
      logic [LANES-1:0]                             read_lanes;
      logic [STAMP_WIDTH-1:0]                       stamp;
      logic [DIRECT_PORTS-1:0]                      stub_valid;
      logic [0:DIRECT_PORTS-1][STUB_WIDTH-1:0]      stubs;
      logic [NEIGHBOUR_PORTS-1:0]                   nb_valid;
      logic [0:NEIGHBOUR_PORTS-1][STUB_WIDTH-1:0]   nbs;
   } stub_cycle_type;

   typedef struct packed {
      logic [LANES-1:0]          popped;
      word_type [0:LANES-1]      words;
      logic [LANES-1:0]          overflow;
   } lane_result_type;

   typedef struct packed {
      int                         reps;
      logic [LANES-1:0]           write_lanes;
      logic [LANES-1:0]           read_lanes;
      logic [STAMP_WIDTH-1:0]     stamp;
      logic [DIRECT_PORTS-1:0]    stub_valid;
      logic [NEIGHBOUR_PORTS-1:0] nb_valid;
      port_data_type              data;
      logic                       known;
      logic [LANES-1:0]           want_popped;
      word_type                   want_word;
      logic [LANES-1:0]           want_overflow;
   } directed_row_type;

   typedef enum int {
      MODE_FILL,
      MODE_DRAIN,
      MODE_MIXED,
      MODE_CHURN
   } traffic_mode_type;

   localparam port_data_type NO_DATA  = '0;
   localparam port_data_type ALL_ONES = '1;
   localparam port_data_type MIXED    = {32'h1111_1111, 32'h2222_2222, 32'h3333_3333,
                                         32'h4444_4444, 32'h5555_5555, 32'hA5A5_A5A5};

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [LANES-1:0]           req_write_lanes = '0;
   logic [LANES-1:0]           req_read_lanes = '0;
   logic [STAMP_WIDTH-1:0]     req_stamp_value = '0;
   logic [DIRECT_PORTS-1:0]    req_stub_valid = '0;
   logic [STUB_WIDTH-1:0]      req_stub_a = '0;
   logic [STUB_WIDTH-1:0]      req_stub_b = '0;
   logic [STUB_WIDTH-1:0]      req_stub_c = '0;
   logic [STUB_WIDTH-1:0]      req_stub_d = '0;
   logic [NEIGHBOUR_PORTS-1:0] req_neighbour_valid = '0;
   logic [STUB_WIDTH-1:0]      req_neighbour_a = '0;
   logic [STUB_WIDTH-1:0]      req_neighbour_b = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [LANES-1:0]           rsp_out_valid;
   word_type                   rsp_lane_word_a;
   word_type                   rsp_lane_word_b;
   word_type                   rsp_lane_word_c;
   word_type                   rsp_lane_word_d;
   logic [LANES-1:0]           rsp_overflow_lanes;

   word_type        lane_mem [LANES][FIFO_DEPTH];
   int              lane_rd [LANES];
   int              lane_wr [LANES];
   int              lane_fill [LANES];
   lane_result_type lane_results_due [$];
   int              mismatches = 0;
   int              results_seen = 0;
   bit              calm_tail = 1'b0;
   int              stall_left = 0;

   directed_row_type directed_rows [12] = '{
      '{1, 4'h0, 4'hF, 32'h0000_0000, 4'h0, 2'h0, NO_DATA,  1'b1, 4'h0, 33'h0, 4'h0},
      '{1, 4'hF, 4'h0, 32'hFFFF_FFFF, 4'h0, 2'h0, ALL_ONES, 1'b1, 4'h0, 33'h0, 4'h0},
      '{1, 4'h0, 4'hF, 32'h0000_0000, 4'h0, 2'h0, NO_DATA,  1'b1, 4'h0, 33'h0, 4'h0},
      '{1, 4'hF, 4'hF, 32'hFFFF_FFFF, 4'hF, 2'h3, ALL_ONES, 1'b1, 4'h0, 33'h0, 4'h0},
      '{1, 4'h0, 4'hF, 32'h0000_0000, 4'h0, 2'h0, NO_DATA,
        1'b1, 4'hF, 33'h0_FFFF_FFFF, 4'h0},
      '{1, 4'h5, 4'h0, 32'h1234_5678, 4'h0, 2'h0, ALL_ONES, 1'b0, 4'h0, 33'h0, 4'h0},
      '{1, 4'hA, 4'h5, 32'h6666_6666, 4'hA, 2'h1, MIXED,    1'b0, 4'h0, 33'h0, 4'h0},
      '{1, 4'h2, 4'hA, 32'h8000_0001, 4'h0, 2'h2, MIXED,    1'b0, 4'h0, 33'h0, 4'h0},
      '{7, 4'hF, 4'h0, 32'h0000_0000, 4'hF, 2'h3, NO_DATA,  1'b0, 4'h0, 33'h0, 4'h0},
      '{1, 4'hF, 4'h0, 32'h0000_0000, 4'hF, 2'h3, MIXED,    1'b0, 4'h0, 33'h0, 4'h0},
      '{1, 4'hF, 4'h0, 32'h7FFF_FFFF, 4'hF, 2'h3, MIXED,    1'b1, 4'h0, 33'h0, 4'hF},
      '{1, 4'hF, 4'hF, 32'hFFFF_FFFF, 4'h1, 2'h0, ALL_ONES, 1'b0, 4'h0, 33'h0, 4'h0}
   };

   multi_lane_stub_fifo_manager_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_write_lanes     (req_write_lanes),
      .req_read_lanes      (req_read_lanes),
      .req_stamp_value     (req_stamp_value),
      .req_stub_valid      (req_stub_valid),
      .req_stub_a          (req_stub_a),
      .req_stub_b          (req_stub_b),
      .req_stub_c          (req_stub_c),
      .req_stub_d          (req_stub_d),
      .req_neighbour_valid (req_neighbour_valid),
      .req_neighbour_a     (req_neighbour_a),
      .req_neighbour_b     (req_neighbour_b),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_valid       (rsp_out_valid),
      .rsp_lane_word_a     (rsp_lane_word_a),
      .rsp_lane_word_b     (rsp_lane_word_b),
      .rsp_lane_word_c     (rsp_lane_word_c),
      .rsp_lane_word_d     (rsp_lane_word_d),
      .rsp_overflow_lanes  (rsp_overflow_lanes)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic push_entry(int lane, word_type entry);
      if (lane_fill[lane] >= FIFO_DEPTH)
         return 1'b1;
      lane_mem[lane][lane_wr[lane]] = entry;
      lane_wr[lane] = (lane_wr[lane] + 1) % FIFO_DEPTH;
      lane_fill[lane]++;
      return 1'b0;
   endfunction

   // pops see the fifo as it was before this request's pushes
   function automatic lane_result_type buffer_and_pop(stub_cycle_type c);
      lane_result_type res;
      logic            dropped;
      res = '0;
      for (int l = 0; l < LANES; l++) begin
         if (c.read_lanes[l] && lane_fill[l] != 0) begin
            res.words[l] = lane_mem[l][lane_rd[l]];
            lane_rd[l] = (lane_rd[l] + 1) % FIFO_DEPTH;
            lane_fill[l]--;
            res.popped[l] = 1'b1;
         end
      end
      for (int l = 0; l < LANES; l++) begin
         if (c.write_lanes[l]) begin
            dropped = 1'b0;
            for (int p = 0; p < DIRECT_PORTS; p++)
               if (c.stub_valid[p])
                  dropped |= push_entry(l, word_type'(c.stubs[p]));
            for (int p = 0; p < NEIGHBOUR_PORTS; p++)
               if (c.nb_valid[p])
                  dropped |= push_entry(l, word_type'(c.nbs[p]));
            if (lane_fill[l] != 0)
               dropped |= push_entry(l, STAMP_TAG | word_type'(c.stamp));
            res.overflow[l] = dropped;
         end
      end
      return res;
   endfunction

   function automatic logic [STUB_WIDTH-1:0] pick_word();
      case ($urandom_range(0, 15))
         0: return '0;
         1: return '1;
         default: return STUB_WIDTH'($urandom);
      endcase
   endfunction

   function automatic stub_cycle_type random_cycle(traffic_mode_type mode);
      stub_cycle_type c;
      c.stamp = STAMP_WIDTH'(pick_word());
      c.stub_valid = DIRECT_PORTS'($urandom);
      c.nb_valid = NEIGHBOUR_PORTS'($urandom);
      for (int p = 0; p < DIRECT_PORTS; p++)
         c.stubs[p] = pick_word();
      for (int p = 0; p < NEIGHBOUR_PORTS; p++)
         c.nbs[p] = pick_word();
      case (mode)
         MODE_FILL: begin
            c.write_lanes = LANES'(~($urandom & $urandom));
            c.read_lanes = LANES'($urandom & $urandom & $urandom);
         end
         MODE_DRAIN: begin
            c.write_lanes = LANES'($urandom & $urandom & $urandom & $urandom);
            c.read_lanes = LANES'(~($urandom & $urandom & $urandom));
         end
         MODE_CHURN: begin
            c.write_lanes = LANES'(~($urandom & $urandom));
            c.read_lanes = LANES'($urandom);
         end
         default: begin
            c.write_lanes = LANES'($urandom);
            c.read_lanes = LANES'($urandom);
         end
      endcase
      return c;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (mismatches < PRINT_LIMIT)
         $display("result %0d: %s got %h expected %h", results_seen, what, got, want);
      mismatches++;
   endtask

   task automatic send_request(stub_cycle_type c, logic known, lane_result_type typed);
      lane_result_type predicted;
      req_valid <= 1'b1;
      req_write_lanes <= c.write_lanes;
      req_read_lanes <= c.read_lanes;
      req_stamp_value <= c.stamp;
      req_stub_valid <= c.stub_valid;
      req_stub_a <= c.stubs[0];
      req_stub_b <= c.stubs[1];
      req_stub_c <= c.stubs[2];
      req_stub_d <= c.stubs[3];
      req_neighbour_valid <= c.nb_valid;
      req_neighbour_a <= c.nbs[0];
      req_neighbour_b <= c.nbs[1];
      do @(posedge clock); while (req_stall);
      predicted = buffer_and_pop(c);
      if (known)
         predicted = typed;
      lane_results_due.insert(lane_results_due.size(), predicted);
   endtask

   task automatic hold_sender(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (lane_results_due.size() != 0)
         @(posedge clock);
   endtask

   // receiver: stall bursts between stretches of free flow
   always @(posedge clock) begin
      if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (!calm_tail && !rsp_stall && $urandom_range(0, 2) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(1, 15);
      end else begin
         rsp_stall <= 1'b0;
         stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 40);
      end
   end

   always @(posedge clock) begin : check_results
      lane_result_type want;
      word_type        got_word [LANES];
      if (!reset && rsp_valid && !rsp_stall) begin
         got_word[0] = rsp_lane_word_a;
         got_word[1] = rsp_lane_word_b;
         got_word[2] = rsp_lane_word_c;
         got_word[3] = rsp_lane_word_d;
         if (lane_results_due.size() == 0) begin
            report_mismatch("unrequested result, out_valid", 64'(rsp_out_valid), 64'h0);
         end else begin
            want = lane_results_due.pop_front();
            if (rsp_out_valid !== want.popped)
               report_mismatch("out_valid", 64'(rsp_out_valid), 64'(want.popped));
            for (int l = 0; l < LANES; l++)
               if (got_word[l] !== want.words[l])
                  report_mismatch($sformatf("lane %0d word", l), 64'(got_word[l]),
                                  64'(want.words[l]));
            if (rsp_overflow_lanes !== want.overflow)
               report_mismatch("overflow_lanes", 64'(rsp_overflow_lanes),
                               64'(want.overflow));
         end
         results_seen++;
      end
   end

   initial begin : stimulus
      directed_row_type row;
      stub_cycle_type   c;
      lane_result_type  typed;
      traffic_mode_type mode;
      int               sent;
      int               phase_len;
      bit               gappy;
      bit               paused;
      for (int l = 0; l < LANES; l++) begin
         lane_rd[l] = 0;
         lane_wr[l] = 0;
         lane_fill[l] = 0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         c.write_lanes = row.write_lanes;
         c.read_lanes = row.read_lanes;
         c.stamp = row.stamp;
         c.stub_valid = row.stub_valid;
         c.nb_valid = row.nb_valid;
         for (int p = 0; p < DIRECT_PORTS; p++)
            c.stubs[p] = row.data[p];
         for (int p = 0; p < NEIGHBOUR_PORTS; p++)
            c.nbs[p] = row.data[DIRECT_PORTS + p];
         typed.popped = row.want_popped;
         typed.overflow = row.want_overflow;
         for (int l = 0; l < LANES; l++)
            typed.words[l] = row.want_popped[l] ? row.want_word : '0;
         repeat (row.reps)
            send_request(c, row.known, typed);
      end
      wait_for_drain();

      sent = 0;
      paused = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         mode = traffic_mode_type'($urandom_range(0, 3));
         phase_len = $urandom_range(20, 120);
         gappy = $urandom_range(0, 2) != 0;
         for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
            calm_tail = (RANDOM_ITEMS - sent) <= CALM_ITEMS;
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
               wait_for_drain();
               paused = 1'b1;
            end
            if (gappy && !calm_tail && $urandom_range(0, 7) == 0)
               hold_sender($urandom_range(1, 15));
            send_request(random_cycle(mode), 1'b0, '0);
            sent++;
         end
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
design/mlsfm_pkg.sv
design/mlsfm_ram.sv
design/mlsfm_lane.sv
design/multi_lane_stub_fifo_manager_unit.sv
bench/multi_lane_stub_fifo_manager_unit_test.sv
